// ===== rtl/ppt_pkg.sv =====
// Shared types and constants for the point-in-polygon tester.
package ppt_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 16;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int DIFF_W       = COORD_BITS + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int PIPE_DEPTH   = 3;

    localparam int IN_DATA_W  = 2 * COORD_BITS;
    localparam int IN_USER_W  = 2;
    localparam int OUT_RAW_W  = 1 + CNT_W + 1;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord y;
        t_coord x;
    } t_vertex;

    typedef logic [IN_USER_W-1:0] t_kind;

    localparam t_kind KIND_CLEAR  = 2'd0;
    localparam t_kind KIND_APPEND = 2'd1;
    localparam t_kind KIND_QUERY  = 2'd2;

endpackage

// ===== rtl/point_in_polygon_test.sv =====
// Top level of the point-in-polygon tester: vertex ring, control and result register.
//
// Input words carry a kind in tuser (clear, append vertex, query point) and a
// point in tdata. Every input word produces exactly one output word holding
// the inside flag, the vertex count after the word, and the overflow flag.
// Clear and append words, and queries rejected early (fewer than two
// vertices, or a point outside the half-open bounding box), produce their
// output word in the cycle after acceptance.
// A full query rotates the 64-cell vertex ring once, one edge per cycle
// through a shared three-stage edge unit, then drains that pipeline and
// loads the output word; no new word is taken while a query walks or
// drains, only once the result is loaded and the control is back in idle.
// The walk always spans the full ring capacity, whatever the vertex count.
// The output register holds a finished word while the receiver stalls; a new
// word is accepted only when that register is empty or being emptied.
// Reset empties the vertex list, zeroes the bounding box and drops any
// pending output word; vertex contents are not cleared.
module point_in_polygon_test (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [ppt_pkg::IN_DATA_W-1:0]    i_s_tdata,  // coord_x, coord_y
    input  logic [ppt_pkg::IN_USER_W-1:0]    i_s_tuser,  // kind
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [ppt_pkg::OUT_DATA_W-1:0]   o_m_tdata   // inside_res, vertex_count, overflow
);
    import ppt_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_step, n_step;
    logic [CNT_W-1:0] r_count, n_count;
    t_coord           r_min_x, n_min_x, r_max_x, n_max_x;
    t_coord           r_min_y, n_min_y, r_max_y, n_max_y;
    t_coord           r_px, n_px, r_py, n_py;
    logic             r_parity, n_parity;

    logic             r_out_valid, n_out_valid;
    logic             r_out_inside, n_out_inside;
    logic [CNT_W-1:0] r_out_count, n_out_count;
    logic             r_out_ovf, n_out_ovf;

    t_vertex          cell_vtx [MAX_VERTICES];
    t_vertex          in_vtx;
    t_kind            in_kind;
    logic             accept;
    logic             out_free;
    logic             do_append;
    logic             shift_en;
    logic             edge_valid;
    logic             cross_hit;
    logic             in_box;

    assign in_kind  = i_s_tuser;
    assign in_vtx.x = i_s_tdata[COORD_BITS-1:0];
    assign in_vtx.y = i_s_tdata[2*COORD_BITS-1:COORD_BITS];

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE) && out_free;
    assign accept     = i_s_tvalid && o_s_tready;
    assign do_append  = accept && (in_kind == KIND_APPEND) &&
                        (r_count < CNT_W'(MAX_VERTICES));
    assign shift_en   = (r_state == ST_WALK);

    // Cells 0 and 1 hold vertices i and i+1 during step i of the rotation.
    assign edge_valid = shift_en && ((CNT_W'(r_step) + CNT_W'(1)) < r_count);

    assign in_box = (in_vtx.x >= r_min_x) && (in_vtx.x < r_max_x) &&
                    (in_vtx.y >= r_min_y) && (in_vtx.y < r_max_y);

    genvar k;
    generate
        for (k = 0; k < MAX_VERTICES; k++) begin : g_cell
            ppt_vtx_cell u_cell (
                .i_clk      (i_clk),
                .i_wr_en    (do_append && (r_count[IDX_W-1:0] == IDX_W'(k))),
                .i_wr_vtx   (in_vtx),
                .i_shift_en (shift_en),
                .i_next_vtx (cell_vtx[(k + 1) % MAX_VERTICES]),
                .o_vtx      (cell_vtx[k])
            );
        end
    endgenerate

    ppt_edge_unit u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (edge_valid),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_v1    (cell_vtx[0]),
        .i_v2    (cell_vtx[1]),
        .o_cross (cross_hit)
    );

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_count      = r_count;
        n_min_x      = r_min_x;
        n_max_x      = r_max_x;
        n_min_y      = r_min_y;
        n_max_y      = r_max_y;
        n_px         = r_px;
        n_py         = r_py;
        n_parity     = r_parity ^ cross_hit;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_inside = r_out_inside;
        n_out_count  = r_out_count;
        n_out_ovf    = r_out_ovf;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_out_valid  = 1'b1;
                    n_out_inside = 1'b0;
                    n_out_ovf    = 1'b0;
                    n_out_count  = r_count;
                    case (in_kind)
                        KIND_CLEAR: begin
                            n_count     = '0;
                            n_min_x     = '0;
                            n_max_x     = '0;
                            n_min_y     = '0;
                            n_max_y     = '0;
                            n_out_count = '0;
                        end
                        KIND_APPEND: begin
                            if (do_append) begin
                                n_count     = r_count + CNT_W'(1);
                                n_out_count = r_count + CNT_W'(1);
                                if (r_count == CNT_W'(1)) begin
                                    // Second vertex: the box spans vertex 0 and this one.
                                    n_min_x = (in_vtx.x < cell_vtx[0].x) ? in_vtx.x : cell_vtx[0].x;
                                    n_max_x = (in_vtx.x > cell_vtx[0].x) ? in_vtx.x : cell_vtx[0].x;
                                    n_min_y = (in_vtx.y < cell_vtx[0].y) ? in_vtx.y : cell_vtx[0].y;
                                    n_max_y = (in_vtx.y > cell_vtx[0].y) ? in_vtx.y : cell_vtx[0].y;
                                end else if (r_count > CNT_W'(1)) begin
                                    if (in_vtx.x < r_min_x) n_min_x = in_vtx.x;
                                    if (in_vtx.x > r_max_x) n_max_x = in_vtx.x;
                                    if (in_vtx.y < r_min_y) n_min_y = in_vtx.y;
                                    if (in_vtx.y > r_max_y) n_max_y = in_vtx.y;
                                end
                            end else begin
                                n_out_ovf = 1'b1;
                            end
                        end
                        KIND_QUERY: begin
                            if ((r_count >= CNT_W'(2)) && in_box) begin
                                // Full walk; the output word is loaded at the end.
                                n_out_valid = 1'b0;
                                n_px        = in_vtx.x;
                                n_py        = in_vtx.y;
                                n_parity    = 1'b0;
                                n_step      = '0;
                                n_state     = ST_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WALK: begin
                n_step = r_step + IDX_W'(1);
                if (r_step == IDX_W'(MAX_VERTICES - 1)) begin
                    n_step  = '0;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_step = r_step + IDX_W'(1);
                if (r_step == IDX_W'(PIPE_DEPTH - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_inside = r_parity;
                    n_out_count  = r_count;
                    n_out_ovf    = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_count     <= '0;
            r_min_x     <= '0;
            r_max_x     <= '0;
            r_min_y     <= '0;
            r_max_y     <= '0;
            r_parity    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_count     <= n_count;
            r_min_x     <= n_min_x;
            r_max_x     <= n_max_x;
            r_min_y     <= n_min_y;
            r_max_y     <= n_max_y;
            r_parity    <= n_parity;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px         <= n_px;
        r_py         <= n_py;
        r_out_inside <= n_out_inside;
        r_out_count  <= n_out_count;
        r_out_ovf    <= n_out_ovf;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_W'({r_out_ovf, r_out_count, r_out_inside});

endmodule

// ===== rtl/ppt_vtx_cell.sv =====
// One vertex cell of the rotating vertex ring.
module ppt_vtx_cell (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  ppt_pkg::t_vertex i_wr_vtx,
    input  logic            i_shift_en,
    input  ppt_pkg::t_vertex i_next_vtx,
    output ppt_pkg::t_vertex o_vtx
);
    import ppt_pkg::*;

    t_vertex r_vtx;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_vtx <= i_wr_vtx;
        end else if (i_shift_en) begin
            r_vtx <= i_next_vtx;
        end
    end

    assign o_vtx = r_vtx;

endmodule

// ===== rtl/ppt_edge_unit.sv =====
// Three-stage edge crossing test: differences, cross products, signed compare.
module ppt_edge_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  ppt_pkg::t_coord  i_px,
    input  ppt_pkg::t_coord  i_py,
    input  ppt_pkg::t_vertex i_v1,
    input  ppt_pkg::t_vertex i_v2,
    output logic             o_cross
);
    import ppt_pkg::*;

    logic                     r1_vld;
    logic                     r1_dy_pos;
    logic signed [DIFF_W-1:0] r1_a;
    logic signed [DIFF_W-1:0] r1_dy;
    logic signed [DIFF_W-1:0] r1_b;
    logic signed [DIFF_W-1:0] r1_dx;

    logic                     r2_vld;
    logic                     r2_dy_pos;
    logic signed [PROD_W-1:0] r2_p1;
    logic signed [PROD_W-1:0] r2_p2;

    logic r3_cross;
    logic straddle;

    // Half-open straddle of the point's y; it also guarantees dy is nonzero.
    assign straddle = ((i_v1.y <= i_py) && (i_v2.y > i_py)) ||
                      ((i_v1.y > i_py) && (i_v2.y <= i_py));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld   <= 1'b0;
            r2_vld   <= 1'b0;
            r3_cross <= 1'b0;
        end else begin
            r1_vld   <= i_valid && straddle;
            r2_vld   <= r1_vld;
            r3_cross <= r2_vld && (r2_dy_pos ? (r2_p1 < r2_p2) : (r2_p1 > r2_p2));
        end
    end

    always_ff @(posedge i_clk) begin
        r1_dy_pos <= i_v2.y > i_v1.y;
        r1_a      <= {i_px[COORD_BITS-1], i_px} - {i_v1.x[COORD_BITS-1], i_v1.x};
        r1_dy     <= {i_v2.y[COORD_BITS-1], i_v2.y} - {i_v1.y[COORD_BITS-1], i_v1.y};
        r1_b      <= {i_py[COORD_BITS-1], i_py} - {i_v1.y[COORD_BITS-1], i_v1.y};
        r1_dx     <= {i_v2.x[COORD_BITS-1], i_v2.x} - {i_v1.x[COORD_BITS-1], i_v1.x};
        r2_dy_pos <= r1_dy_pos;
        r2_p1     <= r1_a * r1_dy;
        r2_p2     <= r1_b * r1_dx;
    end

    assign o_cross = r3_cross;

endmodule
